// ----- rtl/fcrc_pkg.sv -----
// Shared types and constants for the field column remap compactor.
package fcrc_pkg;

	localparam int unsigned FIELD_W   = 64;
	localparam int unsigned IDX_W     = 6;
	localparam int unsigned CNT_W     = 7;
	localparam int unsigned CMD_W     = 2;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned LANES     = 8;
	localparam int unsigned LANE_W    = 8;
	localparam int unsigned LCNT_W    = 4;
	localparam int unsigned LRANK_W   = 3;

	localparam logic [CFG_IDX_W-1:0] REG_STORED_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_COUNT = 2'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_F2C     = 2'd0,
		CMD_C2F     = 2'd1,
		CMD_COMPACT = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_NOT_STORED = 2'd1,
		ST_RANGE      = 2'd2
	} status_t;

	typedef struct packed {
		logic [FIELD_W-1:0] stored;
		logic [CNT_W-1:0]   nf;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [IDX_W-1:0]   index_in;
		logic [FIELD_W-1:0] field_bits;
		logic [FIELD_W-1:0] used;
		logic [FIELD_W-1:0] s;
		logic [CNT_W-1:0]   nf;
	} s1_t;

	typedef struct packed {
		logic [CMD_W-1:0]                 command;
		logic [IDX_W-1:0]                 index_in;
		logic [FIELD_W-1:0]               field_bits;
		logic [FIELD_W-1:0]               s;
		logic [CNT_W-1:0]                 nf;
		logic                             compact;
		logic [FIELD_W-1:0][LRANK_W-1:0]  lrank;
		logic [LANES-1:0][LCNT_W-1:0]     bcnt;
	} s2_t;

	typedef struct packed {
		logic [CMD_W-1:0]               command;
		logic [IDX_W-1:0]               index_in;
		logic [FIELD_W-1:0]             field_bits;
		logic [FIELD_W-1:0]             s;
		logic [CNT_W-1:0]               nf;
		logic                           compact;
		logic [FIELD_W-1:0][CNT_W-1:0]  rank;
		logic [CNT_W-1:0]               nstored;
	} s3_t;

endpackage

// ----- rtl/fcrc_cfg.sv -----
// Configuration registers: stored-field mask and clamped field count.
module fcrc_cfg #(
	parameter int unsigned MAX_FIELDS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [fcrc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fcrc_pkg::FIELD_W-1:0]    cfg_data,
	output fcrc_pkg::cfg_t                  cfg
);
	import fcrc_pkg::*;

	logic [MAX_FIELDS-1:0] stored_q;
	logic [CNT_W-1:0]      nf_q;
	logic                  wr;

	assign wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '1;
			nf_q     <= CNT_W'(MAX_FIELDS);
		end else if (wr) begin
			if (cfg_index == REG_STORED_MASK) begin
				stored_q <= cfg_data[MAX_FIELDS-1:0];
			end else if (cfg_index == REG_FIELD_COUNT) begin
				if (cfg_data[CNT_W-1:0] > CNT_W'(MAX_FIELDS)) begin
					nf_q <= CNT_W'(MAX_FIELDS);
				end else begin
					nf_q <= cfg_data[CNT_W-1:0];
				end
			end
		end
	end

	assign cfg.stored = FIELD_W'(stored_q);
	assign cfg.nf     = nf_q;

endmodule

// ----- rtl/fcrc_rank.sv -----
// Front stages: capture, lane prefix counts and gap check, full rank per field.
module fcrc_rank (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [fcrc_pkg::CMD_W-1:0]    command,
	input  logic [fcrc_pkg::IDX_W-1:0]    index_in,
	input  logic [fcrc_pkg::FIELD_W-1:0]  field_bits,
	input  fcrc_pkg::cfg_t                cfg,
	output logic                          v_s3,
	output fcrc_pkg::s3_t                 d_s3
);
	import fcrc_pkg::*;

	logic               v_s1, v_s2;
	s1_t                d_s1, n_s1;
	s2_t                d_s2, n_s2;
	s3_t                n_s3;
	logic [FIELD_W-1:0] used;
	logic [FIELD_W-1:0] zero_bits, low_zero, moved;
	logic [LCNT_W-1:0]  lcnt;
	logic [CNT_W-1:0]   base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= n_s1;
		d_s2 <= n_s2;
		d_s3 <= n_s3;
	end

	always_comb begin
		for (int i = 0; i < FIELD_W; i++) begin
			used[i] = (CNT_W'(i) < cfg.nf);
		end
		n_s1.command    = command;
		n_s1.index_in   = index_in;
		n_s1.field_bits = field_bits;
		n_s1.used       = used;
		n_s1.s          = cfg.stored & used;
		n_s1.nf         = cfg.nf;
	end

	always_comb begin
		zero_bits = d_s1.used & ~d_s1.s;
		low_zero  = zero_bits & (~zero_bits + FIELD_W'(1));
		moved     = d_s1.used & ~(low_zero | (low_zero - FIELD_W'(1)));
		n_s2.command    = d_s1.command;
		n_s2.index_in   = d_s1.index_in;
		n_s2.field_bits = d_s1.field_bits;
		n_s2.s          = d_s1.s;
		n_s2.nf         = d_s1.nf;
		n_s2.compact    = |(d_s1.field_bits & moved);
		lcnt = '0;
		for (int b = 0; b < LANES; b++) begin
			lcnt = '0;
			for (int j = 0; j < LANE_W; j++) begin
				n_s2.lrank[b*LANE_W+j] = lcnt[LRANK_W-1:0];
				lcnt = lcnt + LCNT_W'(d_s1.s[b*LANE_W+j]);
			end
			n_s2.bcnt[b] = lcnt;
		end
	end

	always_comb begin
		n_s3.command    = d_s2.command;
		n_s3.index_in   = d_s2.index_in;
		n_s3.field_bits = d_s2.field_bits;
		n_s3.s          = d_s2.s;
		n_s3.nf         = d_s2.nf;
		n_s3.compact    = d_s2.compact;
		base = '0;
		for (int b = 0; b < LANES; b++) begin
			for (int j = 0; j < LANE_W; j++) begin
				n_s3.rank[b*LANE_W+j] = base + CNT_W'(d_s2.lrank[b*LANE_W+j]);
			end
			base = base + CNT_W'(d_s2.bcnt[b]);
		end
		n_s3.nstored = base;
	end

endmodule

// ----- rtl/fcrc_resolve.sv -----
// Final stage: command decode, index lookup, mask compaction, result register.
module fcrc_resolve (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           v_s3,
	input  fcrc_pkg::s3_t                  d_s3,
	output logic                           done,
	output logic [fcrc_pkg::IDX_W-1:0]     index_out,
	output logic [fcrc_pkg::FIELD_W-1:0]   column_mask,
	output logic [fcrc_pkg::STATUS_W-1:0]  status
);
	import fcrc_pkg::*;

	logic               done_s4;
	logic [IDX_W-1:0]   idx_s4, idx_n;
	logic [FIELD_W-1:0] mask_s4, mask_n, packed_mask;
	status_t            status_s4, status_n;
	logic [CNT_W-1:0]   idx_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4 <= 1'b0;
		end else begin
			done_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		idx_s4    <= idx_n;
		mask_s4   <= mask_n;
		status_s4 <= status_n;
	end

	always_comb begin
		idx_w       = CNT_W'(d_s3.index_in);
		idx_n       = '0;
		mask_n      = '0;
		status_n    = ST_OK;
		packed_mask = '0;
		for (int i = 0; i < FIELD_W; i++) begin
			if (d_s3.s[i] && d_s3.field_bits[i]) begin
				packed_mask[d_s3.rank[i][IDX_W-1:0]] = 1'b1;
			end
		end
		case (d_s3.command)
			CMD_F2C: begin
				if (idx_w >= d_s3.nf) begin
					status_n = ST_RANGE;
				end else if (!d_s3.s[d_s3.index_in]) begin
					status_n = ST_NOT_STORED;
				end else begin
					idx_n = d_s3.rank[d_s3.index_in][IDX_W-1:0];
				end
			end
			CMD_C2F: begin
				if (idx_w >= d_s3.nstored) begin
					status_n = ST_RANGE;
				end else begin
					for (int i = 0; i < FIELD_W; i++) begin
						if (d_s3.s[i] && (d_s3.rank[i] == idx_w)) begin
							idx_n = IDX_W'(i);
						end
					end
				end
			end
			CMD_COMPACT: begin
				if (d_s3.compact) begin
					mask_n = packed_mask;
				end else begin
					mask_n = d_s3.field_bits;
				end
			end
			default: begin
				status_n = ST_RANGE;
			end
		endcase
	end

	assign done        = done_s4;
	assign index_out   = idx_s4;
	assign column_mask = mask_s4;
	assign status      = status_s4;

endmodule

// ----- rtl/field_column_remap_compactor.sv -----
// Top level of the field column remap compactor.
// Each item passes the capture, lane-count, rank and result registers before done strobes with its result.
// Throughput: one item per cycle; busy stays low and every start is taken.
// The rank network runs over three register stages, then one result stage.
// Reset clears all pipeline valid bits, sets stored_mask to all ones and
// field_count to MAX_FIELDS; results are never held off by the receiver.
module field_column_remap_compactor #(
	parameter int unsigned MAX_FIELDS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [fcrc_pkg::CMD_W-1:0]      command,
	input  logic [fcrc_pkg::IDX_W-1:0]      index_in,
	input  logic [fcrc_pkg::FIELD_W-1:0]    field_bits,
	output logic                            done,
	output logic [fcrc_pkg::IDX_W-1:0]      index_out,
	output logic [fcrc_pkg::FIELD_W-1:0]    column_mask,
	output logic [fcrc_pkg::STATUS_W-1:0]   status,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fcrc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fcrc_pkg::FIELD_W-1:0]    cfg_data
);
	import fcrc_pkg::*;

	cfg_t  cfg;
	logic  accept;
	logic  v_s3;
	s3_t   d_s3;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	fcrc_cfg #(
		.MAX_FIELDS(MAX_FIELDS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fcrc_rank u_rank (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.command    (command),
		.index_in   (index_in),
		.field_bits (field_bits),
		.cfg        (cfg),
		.v_s3       (v_s3),
		.d_s3       (d_s3)
	);

	fcrc_resolve u_resolve (
		.clk         (clk),
		.arst_n      (arst_n),
		.v_s3        (v_s3),
		.d_s3        (d_s3),
		.done        (done),
		.index_out   (index_out),
		.column_mask (column_mask),
		.status      (status)
	);

endmodule

// ----- rtl/fcrc_checker.sv -----
// Port-level checker for the field column remap compactor, with its bind.
module fcrc_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic                            done,
	input  logic [fcrc_pkg::IDX_W-1:0]      index_out,
	input  logic [fcrc_pkg::FIELD_W-1:0]    column_mask,
	input  logic [fcrc_pkg::STATUS_W-1:0]   status
);
	import fcrc_pkg::*;

	logic accept;

	assign accept = start && !busy;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		($past(accept, 4) && $past(arst_n, 4) && $past(arst_n, 3) &&
		 $past(arst_n, 2) && $past(arst_n, 1)) |-> done)
		else $error("accepted item produced no result");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("result without a matching accepted item");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> ((index_out == '0) && (column_mask == '0)))
		else $error("error result carries nonzero payload");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((status == ST_OK) || (status == ST_NOT_STORED) || (status == ST_RANGE)))
		else $error("undefined status code");

	a_mask_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (column_mask != '0)) |-> ((status == ST_OK) && (index_out == '0)))
		else $error("mask result mixed with index result");

endmodule

bind field_column_remap_compactor fcrc_checker u_fcrc_checker (.*);
